// ----- rtl/core/tmx_pkg.sv -----
// Package with the shared types, codes and constants of the ticket mutual exclusion node.
`timescale 1ns / 1ps

package tmx_pkg;

   // Default group limit; ids on the wire stay four bits wide.
   localparam int MAX_NODES_DEFAULT = 16;
   localparam int PEER_SLOTS        = 16;
   localparam int TICKET_WIDTH      = 32;
   localparam int NODE_ID_WIDTH     = 4;
   localparam int COUNT_WIDTH       = 5;
   localparam int CSR_INDEX_WIDTH   = 1;
   localparam int CSR_DATA_WIDTH    = 5;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OWN_NODE_ID = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NODE_COUNT  = 1'd1;

   // Reset value and lower clamp of the group size.
   localparam logic [COUNT_WIDTH-1:0] NODE_COUNT_MIN = 5'd2;

   // Input actions.
   localparam logic [1:0] ACT_PEER_REQUEST = 2'd0;
   localparam logic [1:0] ACT_PEER_REPLY   = 2'd1;
   localparam logic [1:0] ACT_LOCAL_ENTER  = 2'd2;
   localparam logic [1:0] ACT_LOCAL_LEAVE  = 2'd3;

   // Outgoing message kinds.
   localparam logic [1:0] KIND_REQUEST = 2'd0;
   localparam logic [1:0] KIND_REPLY   = 2'd1;
   localparam logic [1:0] KIND_GRANT   = 2'd2;

   typedef struct packed {
      logic [1:0]              action;
      logic [NODE_ID_WIDTH-1:0] source_node;
      logic [TICKET_WIDTH-1:0]  peer_ticket;
   } req_type;

   typedef struct packed {
      logic [1:0]              msg_kind;
      logic [NODE_ID_WIDTH-1:0] dest_node;
      logic [TICKET_WIDTH-1:0]  ticket_out;
      logic                    last;
   } rsp_type;

   // Operations of the shared ticket unit.
   typedef enum logic [0:0] {
      ALU_COMPARE,
      ALU_INCREMENT
   } alu_op_type;

   typedef struct packed {
      alu_op_type              op;
      logic [TICKET_WIDTH-1:0] a;
      logic [TICKET_WIDTH-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic                    lt;
      logic                    eq;
      logic [TICKET_WIDTH-1:0] sum;
   } alu_res_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_PEER_DECIDE,
      ST_SEND_REQ,
      ST_SEND_REPLY
   } state_type;

endpackage

// ----- rtl/core/tmx_alu.sv -----
// Shared ticket unit: one 32-bit compare and one increment for the dispatch and decide steps.
`timescale 1ns / 1ps

module tmx_alu (
   input  tmx_pkg::alu_req_type alu_req,
   output tmx_pkg::alu_res_type alu_res
);
   import tmx_pkg::*;

   // Compare a against b; the increment only matters when a new ticket is drawn.
   always_comb begin
      alu_res.lt  = (alu_req.a < alu_req.b);
      alu_res.eq  = (alu_req.a == alu_req.b);
      alu_res.sum = (alu_req.op == ALU_INCREMENT) ? alu_req.a + 32'd1 : alu_req.a;
   end

endmodule

// ----- rtl/core/ticket_mutual_exclusion_node.sv -----
// Top level of the ticket mutual exclusion node: sequencer, state and result register.
//
//   channel   ports                                   transfer when
//   -------   -------------------------------------   ------------------------
//   input     start, busy, req_data                   start high, busy low
//   result    rsp_strobe, rsp_data                    every cycle rsp_strobe is high
//   config    csr_write_enable, csr_index, csr_write_data   csr_write_enable high
//
// Every item first passes the dispatch step. A peer request then goes to the decide
// step (one from the own id is dropped), a local entry sends its requests in the
// send-request step (none when already competing), and a leave walks the deferred set
// in the send-reply step up to the highest deferred peer. Each result is registered and
// shows in the cycle after the sequencer step that issues it.
// All ticket compares and the ticket increment go through one shared unit.
// Reset is synchronous and returns the node to the idle, non-competing state.
// The receiver cannot stall: each result is shown for one cycle only.
`timescale 1ns / 1ps

module ticket_mutual_exclusion_node #(
   parameter int MAX_NODES = tmx_pkg::MAX_NODES_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  tmx_pkg::req_type                       req_data,
   output logic                                   rsp_strobe,
   output tmx_pkg::rsp_type                       rsp_data,
   input  logic                                   csr_write_enable,
   input  logic [tmx_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [tmx_pkg::CSR_DATA_WIDTH-1:0]     csr_write_data
);
   import tmx_pkg::*;

   localparam int NW = $clog2(MAX_NODES + 1);
   localparam int IW = $clog2(MAX_NODES);

   state_type                state_ff, state_in;
   req_type                  item_ff, item_in;
   logic [NODE_ID_WIDTH-1:0] own_id_ff;
   logic [COUNT_WIDTH-1:0]   node_count_ff;
   logic                     competing_ff, competing_in;
   logic [TICKET_WIDTH-1:0]  own_ticket_ff, own_ticket_in;
   logic [TICKET_WIDTH-1:0]  highest_ff, highest_in;
   logic [NW-1:0]            replies_ff, replies_in;
   logic [PEER_SLOTS-1:0]    deferred_ff, deferred_in;
   logic [PEER_SLOTS-1:0]    pending_ff, pending_in;
   logic [NODE_ID_WIDTH-1:0] slot_ff, slot_in;
   logic [IW-1:0]            scan_ff, scan_in;
   logic [NW-1:0]            sent_ff, sent_in;
   logic                     rsp_strobe_ff, rsp_strobe_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic [NW-1:0]            group_size;
   logic [NW-1:0]            group_less_one;
   logic                     req_last;
   alu_req_type              alu_req;
   alu_res_type              alu_res;

   tmx_alu u_alu (
      .alu_req (alu_req),
      .alu_res (alu_res)
   );

   // Group size clamped to the supported range.
   always_comb begin
      if (node_count_ff < NODE_COUNT_MIN) begin
         group_size = NW'(2);
      end else if (32'(node_count_ff) > MAX_NODES) begin
         group_size = NW'(MAX_NODES);
      end else begin
         group_size = NW'(node_count_ff);
      end
      group_less_one = group_size - NW'(1);
   end

   assign req_last = ((sent_ff + NW'(1)) == group_less_one);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff     <= '0;
         node_count_ff <= NODE_COUNT_MIN;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_OWN_NODE_ID: own_id_ff     <= csr_write_data[NODE_ID_WIDTH-1:0];
            CSR_NODE_COUNT:  node_count_ff <= csr_write_data[COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Control and node state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         competing_ff  <= 1'b0;
         own_ticket_ff <= '0;
         highest_ff    <= '0;
         replies_ff    <= '0;
         deferred_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         competing_ff  <= competing_in;
         own_ticket_ff <= own_ticket_in;
         highest_ff    <= highest_in;
         replies_ff    <= replies_in;
         deferred_ff   <= deferred_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Item, scan and result payload registers.
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      pending_ff  <= pending_in;
      slot_ff     <= slot_in;
      scan_ff     <= scan_in;
      sent_ff     <= sent_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Sequencer: next state, state updates and the message of this cycle.
   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      competing_in  = competing_ff;
      own_ticket_in = own_ticket_ff;
      highest_in    = highest_ff;
      replies_in    = replies_ff;
      deferred_in   = deferred_ff;
      pending_in    = pending_ff;
      slot_in       = slot_ff;
      scan_in       = scan_ff;
      sent_in       = sent_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      alu_req.op    = ALU_COMPARE;
      alu_req.a     = highest_ff;
      alu_req.b     = item_ff.peer_ticket;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_in  = req_data;
               state_in = ST_DISPATCH;
            end
         end

         ST_DISPATCH: begin
            state_in = ST_IDLE;
            unique case (item_ff.action)
               ACT_PEER_REQUEST: begin
                  // A request from our own id is dropped; otherwise raise the highest ticket.
                  if (item_ff.source_node != own_id_ff) begin
                     if (alu_res.lt) begin
                        highest_in = item_ff.peer_ticket;
                     end
                     state_in = ST_PEER_DECIDE;
                  end
               end
               ACT_PEER_REPLY: begin
                  if (competing_ff && (replies_ff < group_less_one)) begin
                     replies_in = replies_ff + NW'(1);
                     if ((replies_ff + NW'(1)) == group_less_one) begin
                        rsp_strobe_in          = 1'b1;
                        rsp_data_in.msg_kind   = KIND_GRANT;
                        rsp_data_in.dest_node  = own_id_ff;
                        rsp_data_in.ticket_out = '0;
                        rsp_data_in.last       = 1'b1;
                     end
                  end
               end
               ACT_LOCAL_ENTER: begin
                  // Draw a new ticket one above the highest seen, then broadcast.
                  if (!competing_ff) begin
                     alu_req.op    = ALU_INCREMENT;
                     own_ticket_in = alu_res.sum;
                     highest_in    = alu_res.sum;
                     competing_in  = 1'b1;
                     replies_in    = '0;
                     scan_in       = '0;
                     sent_in       = '0;
                     state_in      = ST_SEND_REQ;
                  end
               end
               default: begin
                  // Leave: stop competing and release every deferred peer.
                  competing_in = 1'b0;
                  replies_in   = '0;
                  pending_in   = deferred_ff;
                  deferred_in  = '0;
                  slot_in      = '0;
                  if (deferred_ff != '0) begin
                     state_in = ST_SEND_REPLY;
                  end
               end
            endcase
         end

         ST_PEER_DECIDE: begin
            // Reply at once unless our (ticket, id) pair wins; otherwise defer the peer.
            alu_req.a = item_ff.peer_ticket;
            alu_req.b = own_ticket_ff;
            if (!competing_ff || alu_res.lt ||
                (alu_res.eq && (item_ff.source_node < own_id_ff))) begin
               rsp_strobe_in          = 1'b1;
               rsp_data_in.msg_kind   = KIND_REPLY;
               rsp_data_in.dest_node  = item_ff.source_node;
               rsp_data_in.ticket_out = '0;
               rsp_data_in.last       = 1'b1;
            end else begin
               deferred_in = deferred_ff | (PEER_SLOTS'(1) << item_ff.source_node);
            end
            state_in = ST_IDLE;
         end

         ST_SEND_REQ: begin
            // One request per cycle to every node but ourselves; no request in the step at our own id.
            scan_in = scan_ff + IW'(1);
            if (32'(scan_ff) != 32'(own_id_ff)) begin
               rsp_strobe_in          = 1'b1;
               rsp_data_in.msg_kind   = KIND_REQUEST;
               rsp_data_in.dest_node  = NODE_ID_WIDTH'(scan_ff);
               rsp_data_in.ticket_out = own_ticket_ff;
               rsp_data_in.last       = req_last;
               sent_in                = sent_ff + NW'(1);
               if (req_last) begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_SEND_REPLY: begin
            // Walk the deferred set from the lowest id upward.
            pending_in = pending_ff >> 1;
            slot_in    = slot_ff + NODE_ID_WIDTH'(1);
            if (pending_ff[0]) begin
               rsp_strobe_in          = 1'b1;
               rsp_data_in.msg_kind   = KIND_REPLY;
               rsp_data_in.dest_node  = slot_ff;
               rsp_data_in.ticket_out = '0;
               rsp_data_in.last       = (pending_ff[PEER_SLOTS-1:1] == '0);
            end
            if (pending_ff[PEER_SLOTS-1:1] == '0) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ----- rtl/core/tmx_checker.sv -----
// Port-level checker for the ticket mutual exclusion node and its bind.
`timescale 1ns / 1ps

module tmx_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input tmx_pkg::req_type req_data,
   input logic             rsp_strobe,
   input tmx_pkg::rsp_type rsp_data
);
   import tmx_pkg::*;

   // An accepted transfer always starts work.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("node not busy after an accepted transfer");

   // Results come only from work done in the previous cycle.
   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without preceding work");

   // A grant is always the final result of its item.
   a_grant_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.msg_kind == KIND_GRANT)) |-> rsp_data.last)
      else $error("grant not marked last");

   // Only requests carry a ticket.
   a_ticket_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.msg_kind != KIND_REQUEST)) |-> (rsp_data.ticket_out == '0))
      else $error("reply or grant with nonzero ticket");

   // No message code outside request, reply and grant.
   a_kind_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_data.msg_kind == KIND_REQUEST) ||
                      (rsp_data.msg_kind == KIND_REPLY) ||
                      (rsp_data.msg_kind == KIND_GRANT)))
      else $error("unknown message kind");

endmodule

bind ticket_mutual_exclusion_node tmx_checker u_checker (.*);
